/* src/spg_pkg.sv */
// Shared types, constants and controller/datapath command structures for the slot pool.
`default_nettype none
package spg_pkg;
    localparam int SLOTS_DEF = 64;
    localparam int GROUPS_DEF = 256;
    localparam int OP_W = 2;
    localparam int SLOT_W = 6;
    localparam int GROUP_W = 8;
    localparam int STATUS_W = 2;
    localparam int LINK_W = 7;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_KILL = 2'd1;
    localparam logic [OP_W-1:0] OP_MOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_INSPECT = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_RD_SLOT,
        CMD_CREATE,
        CMD_GWALK_START,
        CMD_GWALK_STEP,
        CMD_AWALK_START,
        CMD_AWALK_STEP,
        CMD_KILL_FIN,
        CMD_MOVE_FIN,
        CMD_RD_GHEAD,
        CMD_RD_NHEAD,
        CMD_FINISH,
        CMD_REJECT,
        CMD_CLEAR
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic used;
        logic free_empty;
        logic walk_done;
        logic [OP_W-1:0] op;
    } stat_t;
endpackage
`default_nettype wire

/* src/spg_if.sv */
// Valid/ready channel interface carrying one item payload.
`default_nettype none
interface spg_if #(parameter int W = 1);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/slot_pool_with_group_lists.sv */
// Top level of the slot pool with free, active and per-group linked lists.
// The block takes one request item (op, slot, group) on the in channel and
// returns exactly one result item on the out channel, both valid/ready.
// Create pops the free list and pushes the slot on the active list and on
// its group's list. Kill walks the slot's group list and then the active list
// to find predecessors, one link memory read per cycle, and frees the slot.
// Move walks the old group list, then pushes the slot on the new group.
// Inspect reads a slot's links. Create, inspect and rejected items pass through
// load, slot read and dispatch to the result register; move and kill also
// walk the lists through the link memories.
// After reset the block sweeps the group head table and the free list, one
// entry a cycle, over max(SLOTS, GROUPS) entries; it accepts no item until then.
// The result register holds its item while the receiver stalls; the next
// request is accepted at once, and its result waits for the register to free.
`default_nettype none
module slot_pool_with_group_lists #(
    parameter int SLOTS = spg_pkg::SLOTS_DEF,
    parameter int GROUPS = spg_pkg::GROUPS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    spg_if.sink in,
    spg_if.source out
);
    spg_pkg::cmd_t cmd;
    spg_pkg::stat_t stat;

    spg_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in.valid),
        .in_ready(in.ready),
        .out_valid(out.valid),
        .out_ready(out.ready),
        .stat(stat),
        .cmd(cmd)
    );

    spg_datapath #(.SLOTS(SLOTS), .GROUPS(GROUPS)) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .in_op(in.data[15:14]),
        .in_slot(in.data[13:8]),
        .in_group(in.data[7:0]),
        .stat(stat),
        .status(out.data[45:44]),
        .slot_out(out.data[43:37]),
        .active_first(out.data[36:30]),
        .group_first(out.data[29:23]),
        .slot_next_active(out.data[22:16]),
        .slot_next_member(out.data[15:9]),
        .slot_group(out.data[8:1]),
        .slot_busy(out.data[0])
    );
endmodule
`default_nettype wire

/* src/spg_datapath.sv */
// Datapath of the slot pool: link memories, heads, list walker and result register.
`default_nettype none
module spg_datapath #(
    parameter int SLOTS = spg_pkg::SLOTS_DEF,
    parameter int GROUPS = spg_pkg::GROUPS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire spg_pkg::cmd_t cmd,
    input  wire logic [spg_pkg::OP_W-1:0] in_op,
    input  wire logic [spg_pkg::SLOT_W-1:0] in_slot,
    input  wire logic [spg_pkg::GROUP_W-1:0] in_group,
    output spg_pkg::stat_t stat,
    output logic [spg_pkg::STATUS_W-1:0] status,
    output logic [spg_pkg::LINK_W-1:0] slot_out,
    output logic [spg_pkg::LINK_W-1:0] active_first,
    output logic [spg_pkg::LINK_W-1:0] group_first,
    output logic [spg_pkg::LINK_W-1:0] slot_next_active,
    output logic [spg_pkg::LINK_W-1:0] slot_next_member,
    output logic [spg_pkg::GROUP_W-1:0] slot_group,
    output logic slot_busy
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int LW = spg_pkg::LINK_W;
    localparam logic [LW-1:0] NONE = LW'(SLOTS);
    localparam int CLR_N = (SLOTS > GROUPS) ? SLOTS : GROUPS;
    localparam int CW = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    logic [LW-1:0] active_link [SLOTS];
    logic [LW-1:0] member_link [SLOTS];
    logic [LW-1:0] free_link [SLOTS];
    logic [GW-1:0] owner_group [SLOTS];
    logic [SLOTS-1:0] busy_reg;
    logic [LW-1:0] group_head [GROUPS];
    logic [CW:0] clr_reg;

    logic [LW-1:0] active_head_reg;
    logic [LW-1:0] free_head_reg;
    logic [spg_pkg::OP_W-1:0] op_reg;
    logic [spg_pkg::SLOT_W-1:0] s_reg;
    logic [GW-1:0] g_reg;
    logic [GW-1:0] old_reg;
    logic used_reg;
    logic [LW-1:0] cur_reg;
    logic [LW-1:0] al_s_reg;
    logic [LW-1:0] ml_s_reg;
    logic [LW-1:0] fl_reg;
    logic [LW-1:0] gh_reg;
    logic [LW-1:0] lnk_reg;
    logic [LW-1:0] cnt_reg;
    logic done_reg;

    logic [SW-1:0] s_idx;
    logic [SW-1:0] f_idx;
    logic [SW-1:0] c_idx;
    logic [GW-1:0] g_in;
    logic s_ok;

    assign s_ok = ({1'b0, s_reg} < (spg_pkg::SLOT_W+1)'(SLOTS));
    assign s_idx = SW'(s_reg);
    assign f_idx = SW'(free_head_reg);
    assign c_idx = SW'(lnk_reg);
    assign g_in = GW'({8'd0, in_group} % (16)'(GROUPS));

    assign stat.clear_done = clr_reg[CW];
    assign stat.used = used_reg;
    assign stat.free_empty = (free_head_reg >= NONE);
    assign stat.walk_done = done_reg;
    assign stat.op = op_reg;

    // Heads of group lists: one row per cycle cleared after reset.
    always_ff @(posedge clk)
    begin
        if (cmd == spg_pkg::CMD_CLEAR)
        begin
            if ({1'b0, clr_reg} < (CW+2)'(GROUPS))
            begin
                group_head[GW'(clr_reg)] <= NONE;
            end
        end
        else if (cmd == spg_pkg::CMD_CREATE)
        begin
            group_head[g_reg] <= free_head_reg;
        end
        else if (cmd == spg_pkg::CMD_GWALK_START && gh_reg == LW'(s_reg))
        begin
            group_head[old_reg] <= ml_s_reg;
        end
        else if (cmd == spg_pkg::CMD_MOVE_FIN)
        begin
            group_head[g_reg] <= LW'(s_reg);
        end
        if (cmd == spg_pkg::CMD_LOAD)
        begin
            gh_reg <= group_head[g_in];
        end
        else if (cmd == spg_pkg::CMD_RD_GHEAD)
        begin
            gh_reg <= group_head[old_reg];
        end
        else if (cmd == spg_pkg::CMD_RD_NHEAD)
        begin
            gh_reg <= group_head[g_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd == spg_pkg::CMD_CLEAR)
        begin
            clr_reg <= (clr_reg + 1'b1 == (CW+1)'(CLR_N)) ?
                {1'b1, {CW{1'b0}}} : clr_reg + 1'b1;
        end
    end

    // Free list: clear sweep writes the initial chain.
    always_ff @(posedge clk)
    begin
        if (cmd == spg_pkg::CMD_CLEAR && {1'b0, clr_reg} < (CW+2)'(SLOTS))
        begin
            free_link[SW'(clr_reg)] <= LW'(clr_reg) + 1'b1;
        end
        else if (cmd == spg_pkg::CMD_KILL_FIN)
        begin
            free_link[s_idx] <= free_head_reg;
        end
        fl_reg <= free_link[f_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd == spg_pkg::CMD_CREATE)
        begin
            owner_group[f_idx] <= g_reg;
        end
        else if (cmd == spg_pkg::CMD_MOVE_FIN)
        begin
            owner_group[s_idx] <= g_reg;
        end
        if (cmd == spg_pkg::CMD_RD_SLOT)
        begin
            old_reg <= owner_group[s_idx];
        end
    end

    // Member links and the group walk.
    always_ff @(posedge clk)
    begin
        if (cmd == spg_pkg::CMD_CREATE)
        begin
            member_link[f_idx] <= gh_reg;
        end
        else if (cmd == spg_pkg::CMD_MOVE_FIN)
        begin
            member_link[s_idx] <= gh_reg;
        end
        else if (cmd == spg_pkg::CMD_GWALK_STEP && !done_reg && lnk_reg == LW'(s_reg))
        begin
            member_link[SW'(cur_reg)] <= ml_s_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == spg_pkg::CMD_CREATE)
        begin
            active_link[f_idx] <= active_head_reg;
        end
        else if (cmd == spg_pkg::CMD_AWALK_STEP && !done_reg && lnk_reg == LW'(s_reg))
        begin
            active_link[SW'(cur_reg)] <= al_s_reg;
        end
    end

    // Walk engine: cur_reg is the node, lnk_reg its registered successor.
    always_ff @(posedge clk)
    begin
        case (cmd)
            spg_pkg::CMD_LOAD:
            begin
                op_reg <= in_op;
                s_reg <= in_slot;
                g_reg <= g_in;
            end
            spg_pkg::CMD_RD_SLOT:
            begin
                al_s_reg <= active_link[s_idx];
                ml_s_reg <= member_link[s_idx];
                used_reg <= s_ok && busy_reg[s_idx];
            end
            spg_pkg::CMD_CREATE:
            begin
                al_s_reg <= active_head_reg;
                ml_s_reg <= gh_reg;
            end
            spg_pkg::CMD_MOVE_FIN:
            begin
                ml_s_reg <= gh_reg;
            end
            spg_pkg::CMD_GWALK_START, spg_pkg::CMD_AWALK_START:
            begin
                cur_reg <= (cmd == spg_pkg::CMD_GWALK_START) ? gh_reg : active_head_reg;
                lnk_reg <= (cmd == spg_pkg::CMD_GWALK_START)
                    ? member_link[SW'(gh_reg)] : active_link[SW'(active_head_reg)];
                cnt_reg <= '0;
                done_reg <= (cmd == spg_pkg::CMD_GWALK_START)
                    ? (gh_reg == LW'(s_reg) || gh_reg >= NONE)
                    : (active_head_reg == LW'(s_reg) || active_head_reg >= NONE);
            end
            spg_pkg::CMD_GWALK_STEP, spg_pkg::CMD_AWALK_STEP:
            begin
                if (!done_reg)
                begin
                    if (lnk_reg == LW'(s_reg) || lnk_reg >= NONE
                        || cnt_reg + 1'b1 >= LW'(SLOTS))
                    begin
                        done_reg <= 1'b1;
                    end
                    cur_reg <= lnk_reg;
                    lnk_reg <= (cmd == spg_pkg::CMD_GWALK_STEP)
                        ? member_link[c_idx] : active_link[c_idx];
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            active_head_reg <= NONE;
            free_head_reg <= '0;
        end
        else
        begin
            case (cmd)
                spg_pkg::CMD_CREATE:
                begin
                    busy_reg[f_idx] <= 1'b1;
                    active_head_reg <= free_head_reg;
                    free_head_reg <= fl_reg;
                end
                spg_pkg::CMD_AWALK_START:
                begin
                    if (active_head_reg == LW'(s_reg))
                    begin
                        active_head_reg <= al_s_reg;
                    end
                end
                spg_pkg::CMD_KILL_FIN:
                begin
                    busy_reg[s_idx] <= 1'b0;
                    free_head_reg <= LW'(s_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        case (cmd)
            spg_pkg::CMD_FINISH:
            begin
                status <= spg_pkg::ST_OK;
                active_first <= active_head_reg;
                case (op_reg)
                    spg_pkg::OP_CREATE:
                    begin
                        // Slot was pushed on both lists, so links are the old heads.
                        slot_out <= active_head_reg;
                        group_first <= active_head_reg;
                        slot_next_active <= al_s_reg;
                        slot_next_member <= ml_s_reg;
                        slot_group <= spg_pkg::GROUP_W'(g_reg);
                        slot_busy <= 1'b1;
                    end
                    spg_pkg::OP_KILL:
                    begin
                        slot_out <= s_ok ? LW'(s_reg) : NONE;
                        group_first <= gh_reg;
                        slot_next_active <= NONE;
                        slot_next_member <= NONE;
                        slot_group <= spg_pkg::GROUP_W'(old_reg);
                        slot_busy <= 1'b0;
                    end
                    spg_pkg::OP_MOVE:
                    begin
                        slot_out <= s_ok ? LW'(s_reg) : NONE;
                        group_first <= LW'(s_reg);
                        slot_next_active <= al_s_reg;
                        slot_next_member <= ml_s_reg;
                        slot_group <= spg_pkg::GROUP_W'(g_reg);
                        slot_busy <= 1'b1;
                    end
                    default:
                    begin
                        slot_out <= s_ok ? LW'(s_reg) : NONE;
                        group_first <= gh_reg;
                        slot_next_active <= used_reg ? al_s_reg : NONE;
                        slot_next_member <= used_reg ? ml_s_reg : NONE;
                        slot_group <= used_reg ? spg_pkg::GROUP_W'(old_reg) : '0;
                        slot_busy <= used_reg;
                    end
                endcase
            end
            spg_pkg::CMD_REJECT:
            begin
                status <= (op_reg == spg_pkg::OP_CREATE) ? spg_pkg::ST_EMPTY
                                                         : spg_pkg::ST_NOT_USED;
                slot_out <= (op_reg == spg_pkg::OP_CREATE || !s_ok) ? NONE : LW'(s_reg);
                active_first <= active_head_reg;
                group_first <= gh_reg;
                slot_next_active <= NONE;
                slot_next_member <= NONE;
                slot_group <= '0;
                slot_busy <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

/* src/spg_ctrl.sv */
// Controller state machine sequencing each item through the datapath.
`default_nettype none
module spg_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  wire logic out_ready,
    input  wire spg_pkg::stat_t stat,
    output spg_pkg::cmd_t cmd
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_DISPATCH, S_GHEAD, S_GSTART, S_GWALK,
        S_ASTART, S_AWALK, S_KILLFIN, S_MVHEAD, S_MVFIN, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = spg_pkg::CMD_NOP;
        out_valid_next = out_valid;
        in_ready = 1'b0;
        if (out_valid && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                cmd = spg_pkg::CMD_CLEAR;
                if (stat.clear_done)
                begin
                    cmd = spg_pkg::CMD_NOP;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = spg_pkg::CMD_LOAD;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd = spg_pkg::CMD_RD_SLOT;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (stat.op == spg_pkg::OP_CREATE)
                begin
                    if (stat.free_empty)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd = spg_pkg::CMD_CREATE;
                        state_next = S_FIN;
                    end
                end
                else if (stat.op == spg_pkg::OP_INSPECT)
                begin
                    state_next = S_FIN;
                end
                else if (!stat.used)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_GHEAD;
                end
            end
            S_GHEAD:
            begin
                cmd = spg_pkg::CMD_RD_GHEAD;
                state_next = S_GSTART;
            end
            S_GSTART:
            begin
                cmd = spg_pkg::CMD_GWALK_START;
                state_next = S_GWALK;
            end
            S_GWALK:
            begin
                cmd = spg_pkg::CMD_GWALK_STEP;
                if (stat.walk_done)
                begin
                    state_next = (stat.op == spg_pkg::OP_KILL) ? S_ASTART : S_MVHEAD;
                end
            end
            S_ASTART:
            begin
                cmd = spg_pkg::CMD_AWALK_START;
                state_next = S_AWALK;
            end
            S_AWALK:
            begin
                cmd = spg_pkg::CMD_AWALK_STEP;
                if (stat.walk_done)
                begin
                    state_next = S_KILLFIN;
                end
            end
            S_KILLFIN:
            begin
                cmd = spg_pkg::CMD_KILL_FIN;
                state_next = S_MVHEAD;
            end
            S_MVHEAD:
            begin
                // Reread the relevant group head after the unlink.
                cmd = (stat.op == spg_pkg::OP_KILL) ? spg_pkg::CMD_RD_GHEAD
                                                    : spg_pkg::CMD_RD_NHEAD;
                state_next = (stat.op == spg_pkg::OP_KILL) ? S_FIN : S_MVFIN;
            end
            S_MVFIN:
            begin
                cmd = spg_pkg::CMD_MOVE_FIN;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_next)
                begin
                    cmd = spg_pkg::CMD_FINISH;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (!out_valid_next)
                begin
                    cmd = spg_pkg::CMD_REJECT;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid <= out_valid_next;
        end
    end
endmodule
`default_nettype wire
